// ===== hw/rtl/light_fan_relay_controller_macros.svh =====
// Assertion macros used by the checker of this project.
`ifndef LIGHT_FAN_RELAY_CONTROLLER_MACROS_SVH
`define LIGHT_FAN_RELAY_CONTROLLER_MACROS_SVH

// Checked only outside reset.
`define LFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lfr_pkg.sv =====
`default_nettype none

package lfr_pkg;

  localparam int OP_W     = 2;
  localparam int HOUR_W   = 5;
  localparam int TEMP_W   = 12;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int MS_PER_SECOND = 1000;
  // 4095 s * 1000 fits in 22 bits
  localparam int DEB_MS_W = 22;

  typedef enum logic [OP_W-1:0] {
    OP_EVAL      = 2'd0,
    OP_LIGHT_SET = 2'd1,
    OP_FAN_SET   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_ON_HOUR    = 3'd0,
    REG_LIGHT_OFF_HOUR   = 3'd1,
    REG_AUTO_FAN_ENABLE  = 3'd2,
    REG_FAN_ON_TEMP      = 3'd3,
    REG_FAN_OFF_TEMP     = 3'd4,
    REG_DEBOUNCE_SECONDS = 3'd5
  } reg_idx_t;

  localparam logic [HOUR_W-1:0]        RST_LIGHT_ON_HOUR  = 5'd6;
  localparam logic [HOUR_W-1:0]        RST_LIGHT_OFF_HOUR = 5'd18;
  localparam logic signed [TEMP_W-1:0] RST_FAN_ON_TEMP    = 12'sd280;
  localparam logic signed [TEMP_W-1:0] RST_FAN_OFF_TEMP   = 12'sd250;
  localparam logic [DEB_MS_W-1:0]      RST_DEBOUNCE_MS    = 22'd60000;

  typedef struct packed {
    logic light_on;
    logic fan_on;
    logic light_override;
    logic fan_override;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfr_cmd_if.sv =====
`default_nettype none

interface lfr_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [lfr_pkg::OP_W-1:0]            op;
  logic [lfr_pkg::HOUR_W-1:0]          hour_of_day;
  logic                                time_valid;
  logic signed [lfr_pkg::TEMP_W-1:0]   air_temp;
  logic                                temp_valid;
  logic [lfr_pkg::TIME_W-1:0]          now_ms;
  logic                                manual_value;

  modport source (
    output valid, op, hour_of_day, time_valid, air_temp, temp_valid, now_ms, manual_value,
    input  ready
  );
  modport sink (
    input  valid, op, hour_of_day, time_valid, air_temp, temp_valid, now_ms, manual_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/lfr_status_if.sv =====
`default_nettype none

interface lfr_status_if;
  logic valid;
  logic ready;
  logic light_on;
  logic fan_on;
  logic light_override;
  logic fan_override;

  modport source (
    output valid, light_on, fan_on, light_override, fan_override,
    input  ready
  );
  modport sink (
    input  valid, light_on, fan_on, light_override, fan_override,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/lfr_cfg_if.sv =====
`default_nettype none

interface lfr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lfr_pkg::CFG_IDX_W-1:0]     index;
  logic [lfr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/light_fan_relay_controller.sv =====
// Channel   Role   Word
// cmd       sink   op, hour_of_day, time_valid, air_temp, temp_valid, now_ms, manual_value
// status    source light_on, fan_on, light_override, fan_override
// cfg       sink   index, data (always ready)
//
// One word in per cycle while skid is empty; its status word goes to output reg or skid.
// Relay state and override latches update at acceptance, set by one stage of
// compare logic (32-bit elapsed-time subtract and compare is the deepest path).
// A two-entry output skid lets cmd keep flowing while status stalls for one word.
// Synchronous reset, active high; no clearing pass.
`default_nettype none

module light_fan_relay_controller (
  input wire logic   clk,
  input wire logic   rst,
  lfr_cmd_if.sink    cmd,
  lfr_status_if.source status,
  lfr_cfg_if.sink    cfg
);
  import lfr_pkg::*;

  logic [HOUR_W-1:0]        light_on_hour;
  logic [HOUR_W-1:0]        light_off_hour;
  logic                     auto_fan_enable;
  logic signed [TEMP_W-1:0] fan_on_temp;
  logic signed [TEMP_W-1:0] fan_off_temp;
  logic [DEB_MS_W-1:0]      debounce_ms;

  logic              light_state, light_state_next;
  logic              fan_state, fan_state_next;
  logic              light_latch, light_latch_next;
  logic              fan_latch, fan_latch_next;
  logic [TIME_W-1:0] last_toggle_ms, last_toggle_ms_next;

  logic    out_valid;
  result_t out_word;
  logic    skid_valid;
  result_t skid_word;
  result_t res;

  logic              accept;
  logic              sched;
  logic              want_on;
  logic              want_off;
  logic              fan_trans;
  logic [TIME_W-1:0] elapsed;
  logic              settled;

  assign cfg.ready = 1'b1;
  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && !skid_valid;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      light_on_hour   <= RST_LIGHT_ON_HOUR;
      light_off_hour  <= RST_LIGHT_OFF_HOUR;
      auto_fan_enable <= 1'b0;
      fan_on_temp     <= RST_FAN_ON_TEMP;
      fan_off_temp    <= RST_FAN_OFF_TEMP;
      debounce_ms     <= RST_DEBOUNCE_MS;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LIGHT_ON_HOUR:    light_on_hour   <= cfg.data[HOUR_W-1:0];
        REG_LIGHT_OFF_HOUR:   light_off_hour  <= cfg.data[HOUR_W-1:0];
        REG_AUTO_FAN_ENABLE:  auto_fan_enable <= cfg.data[0];
        REG_FAN_ON_TEMP:      fan_on_temp     <= signed'(cfg.data[TEMP_W-1:0]);
        REG_FAN_OFF_TEMP:     fan_off_temp    <= signed'(cfg.data[TEMP_W-1:0]);
        REG_DEBOUNCE_SECONDS: debounce_ms     <= DEB_MS_W'(cfg.data[DEB_W-1:0])
                                                 * DEB_MS_W'(MS_PER_SECOND);
        default: ;
      endcase
    end
  end

  // light window, wraps past midnight when on > off
  always_comb begin
    if (light_on_hour == light_off_hour) begin
      sched = 1'b0;
    end else if (light_on_hour < light_off_hour) begin
      sched = (cmd.hour_of_day >= light_on_hour) && (cmd.hour_of_day < light_off_hour);
    end else begin
      sched = (cmd.hour_of_day >= light_on_hour) || (cmd.hour_of_day < light_off_hour);
    end
  end

  assign want_on   = cmd.air_temp >= fan_on_temp;
  assign want_off  = cmd.air_temp <= fan_off_temp;
  assign fan_trans = (fan_state && want_off) || (!fan_state && want_on);
  assign elapsed   = cmd.now_ms - last_toggle_ms;
  assign settled   = elapsed >= {{(TIME_W-DEB_MS_W){1'b0}}, debounce_ms};

  always_comb begin
    light_state_next    = light_state;
    fan_state_next      = fan_state;
    light_latch_next    = light_latch;
    fan_latch_next      = fan_latch;
    last_toggle_ms_next = last_toggle_ms;
    case (cmd.op)
      OP_EVAL: begin
        if (cmd.time_valid && (!light_latch || sched != light_state)) begin
          light_latch_next = 1'b0;
          light_state_next = sched;
        end
        if (auto_fan_enable && cmd.temp_valid && (!fan_latch || fan_trans)) begin
          fan_latch_next = 1'b0;
          if (fan_trans && settled) begin
            fan_state_next      = !fan_state;
            last_toggle_ms_next = cmd.now_ms;
          end
        end
      end
      OP_LIGHT_SET: begin
        light_state_next = cmd.manual_value;
        light_latch_next = 1'b1;
      end
      OP_FAN_SET: begin
        if (cmd.manual_value != fan_state) begin
          last_toggle_ms_next = cmd.now_ms;
        end
        fan_state_next = cmd.manual_value;
        fan_latch_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_state    <= 1'b1;
      fan_state      <= 1'b1;
      light_latch    <= 1'b0;
      fan_latch      <= 1'b0;
      last_toggle_ms <= '0;
    end else if (accept) begin
      light_state    <= light_state_next;
      fan_state      <= fan_state_next;
      light_latch    <= light_latch_next;
      fan_latch      <= fan_latch_next;
      last_toggle_ms <= last_toggle_ms_next;
    end
  end

  assign res = '{light_on:       light_state_next,
                 fan_on:         fan_state_next,
                 light_override: light_latch_next,
                 fan_override:   fan_latch_next};

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || status.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || status.ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= res;
      end
    end else if (accept) begin
      skid_word <= res;
    end
  end

  assign status.valid          = out_valid;
  assign status.light_on       = out_word.light_on;
  assign status.fan_on         = out_word.fan_on;
  assign status.light_override = out_word.light_override;
  assign status.fan_override   = out_word.fan_override;

endmodule

`default_nettype wire

// ===== hw/rtl/lfr_check.sv =====
`default_nettype none

`include "light_fan_relay_controller_macros.svh"

module lfr_check (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     cmd_valid,
  input wire logic                     cmd_ready,
  input wire logic [lfr_pkg::OP_W-1:0] cmd_op,
  input wire logic                     cmd_manual_value,
  input wire logic                     status_valid,
  input wire logic                     status_ready,
  input wire logic                     status_light_on,
  input wire logic                     status_fan_on,
  input wire logic                     status_light_override,
  input wire logic                     status_fan_override
);
  import lfr_pkg::*;

  logic       cmd_acc;
  logic       manual_q;
  logic       light_set_acc;
  logic       fan_set_acc;
  logic       light_ok;
  logic       fan_ok;
  logic       stalled;
  logic [3:0] status_word;

  assign cmd_acc       = cmd_valid && cmd_ready;
  assign light_set_acc = cmd_acc && !status_valid && cmd_op == OP_LIGHT_SET;
  assign fan_set_acc   = cmd_acc && !status_valid && cmd_op == OP_FAN_SET;
  assign light_ok      = status_light_on == manual_q && status_light_override;
  assign fan_ok        = status_fan_on == manual_q && status_fan_override;
  assign stalled       = status_valid && !status_ready;
  assign status_word   = {status_light_on, status_fan_on,
                          status_light_override, status_fan_override};

  always_ff @(posedge clk) begin
    manual_q <= cmd_manual_value;
  end

  `LFR_ASSERT_ALWAYS(a_reset_empty, rst |=> !status_valid, "status valid right after reset")

  `LFR_ASSERT(a_word_follows, cmd_acc && !status_valid |=> status_valid, "accepted word not shown")

  `LFR_ASSERT(a_light_set, light_set_acc |=> light_ok, "light set not applied")

  `LFR_ASSERT(a_fan_set, fan_set_acc |=> fan_ok, "fan set not applied")

  `LFR_ASSERT(a_status_hold, stalled |=> status_valid && $stable(status_word), "word not held")

endmodule

bind light_fan_relay_controller lfr_check u_lfr_check (
  .clk                   (clk),
  .rst                   (rst),
  .cmd_valid             (cmd.valid),
  .cmd_ready             (cmd.ready),
  .cmd_op                (cmd.op),
  .cmd_manual_value      (cmd.manual_value),
  .status_valid          (status.valid),
  .status_ready          (status.ready),
  .status_light_on       (status.light_on),
  .status_fan_on         (status.fan_on),
  .status_light_override (status.light_override),
  .status_fan_override   (status.fan_override)
);

`default_nettype wire
